FILE: hw/rtl/metg_pkg.sv
`default_nettype none
package metg_pkg;

  // frame limits and field widths
  localparam int unsigned MAX_BITS   = 32;
  localparam int unsigned BITS_W     = 6;
  localparam int unsigned TIME_W     = 17;
  localparam int unsigned HALF_W     = 10;
  localparam int unsigned FULL_W     = 11;
  localparam int unsigned STOP_W     = 13;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;

  // register reset values
  localparam logic [HALF_W-1:0] HALF_BIT_RESET = HALF_W'(417);
  localparam logic [FULL_W-1:0] FULL_BIT_RESET = FULL_W'(833);
  localparam logic [STOP_W-1:0] STOP_RESET     = STOP_W'(2450);

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BIT   = 2'd1,
    OP_END   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TOO_MANY = 2'd1,
    ERR_NO_FRAME = 2'd2
  } err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_BIT = 2'd0,
    CFG_FULL_BIT = 2'd1,
    CFG_STOP     = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] edge_time;
    logic              toggle;
    logic              last;
    logic [1:0]        error;
  } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/metg_in_if.sv
`default_nettype none
interface metg_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       bit_value;

  modport source (output valid, output op, output bit_value, input ready);
  modport sink (input valid, input op, input bit_value, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/metg_out_if.sv
`default_nettype none
interface metg_out_if;
  logic                          valid;
  logic                          ready;
  logic [metg_pkg::TIME_W-1:0]   edge_time;
  logic                          toggle;
  logic                          last;
  logic [1:0]                    error;

  modport source (output valid, output edge_time, output toggle, output last,
                  output error, input ready);
  modport sink (input valid, input edge_time, input toggle, input last,
                input error, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/manchester_edge_time_generator_core.sv
`default_nettype none
// Manchester edge time generator: takes a frame one request at a time (start,
// one request per data bit, end) and returns the microsecond time stamps,
// counted from frame start, at which the transmit line toggles, closing each
// frame with a non-toggling marker one stop time after the last edge. Each
// request is decoded and the frame state updated in the cycle it is accepted;
// its one or two results go into a four-entry queue that feeds out_ch one
// result per cycle unless stalled. A request is taken in every cycle while
// the queue holds at most one result, so single-result requests flow at one
// per cycle and a two-result request (equal data bit, or end of frame at a low
// level) takes two entries; the output channel sets the sustained rate. Errors
// (too many bits, no open frame) come back as a single result with edge_time 0.
// Bit times and the stop time must be written through the cfg port while the
// block is idle, which it does not itself enforce; all times wrap modulo 2^17.
module manchester_edge_time_generator_core (
  input  wire                                   clk,
  input  wire                                   rst_n,
  metg_in_if.sink                               in_ch,
  metg_out_if.source                            out_ch,
  input  wire                                   cfg_we,
  input  wire [metg_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  wire [metg_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int unsigned TW = metg_pkg::TIME_W;

  // configuration registers
  logic [metg_pkg::HALF_W-1:0] half_bit_r;
  logic [metg_pkg::FULL_W-1:0] full_bit_r;
  logic [metg_pkg::STOP_W-1:0] stop_r;

  // frame state
  logic [TW-1:0]               cur_time_r, cur_time_nxt;
  logic [TW-1:0]               prev_edge_r, prev_edge_nxt;
  logic [TW-1:0]               pending_r, pending_nxt;
  logic                        level_r, level_nxt;
  logic                        open_r, open_nxt;
  logic [metg_pkg::BITS_W-1:0] bits_r, bits_nxt;

  // result queue
  metg_pkg::result_t           queue_r [4];
  logic [1:0]                  wr_ptr_r, rd_ptr_r;
  logic [1:0]                  count_r, count_nxt;

  logic                        accept, pop;
  logic [1:0]                  n_res;
  metg_pkg::result_t           res0, res1;
  metg_pkg::op_t               op;

  // time sums, all modulo 2^17
  logic [TW-1:0] half_t, full_t, stop_t;
  logic [TW-1:0] cur_plus_half, cur_plus_two_half, prev_plus_full;
  logic [TW-1:0] diff_cur, prev_plus_stop, cur_plus_stop, two_half;

  assign half_t = TW'(half_bit_r);
  assign full_t = TW'(full_bit_r);
  assign stop_t = TW'(stop_r);

  assign two_half          = half_t + half_t;
  assign cur_plus_half     = cur_time_r + half_t;
  assign cur_plus_two_half = cur_plus_half + half_t;
  assign prev_plus_full    = prev_edge_r + full_t;
  assign diff_cur          = prev_plus_full + half_t;
  assign prev_plus_stop    = prev_edge_r + stop_t;
  assign cur_plus_stop     = cur_time_r + stop_t;

  // room for two results whenever at most one is waiting
  assign in_ch.ready = ~count_r[1];
  assign accept      = in_ch.valid & in_ch.ready;
  assign pop         = out_ch.valid & out_ch.ready;
  assign op          = metg_pkg::op_t'(in_ch.op);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_bit_r <= metg_pkg::HALF_BIT_RESET;
      full_bit_r <= metg_pkg::FULL_BIT_RESET;
      stop_r     <= metg_pkg::STOP_RESET;
    end else if (cfg_we) begin
      unique case (metg_pkg::cfg_idx_t'(cfg_idx))
        metg_pkg::CFG_HALF_BIT: half_bit_r <= cfg_wdata[metg_pkg::HALF_W-1:0];
        metg_pkg::CFG_FULL_BIT: full_bit_r <= cfg_wdata[metg_pkg::FULL_W-1:0];
        metg_pkg::CFG_STOP:     stop_r     <= cfg_wdata[metg_pkg::STOP_W-1:0];
        default: ;  // unused index, ignored
      endcase
    end
  end

  // request decode and frame state update
  always_comb begin
    cur_time_nxt  = cur_time_r;
    prev_edge_nxt = prev_edge_r;
    pending_nxt   = pending_r;
    level_nxt     = level_r;
    open_nxt      = open_r;
    bits_nxt      = bits_r;
    n_res         = 2'd0;
    res0          = '{edge_time: '0, toggle: 1'b0, last: 1'b1,
                      error: metg_pkg::ERR_NONE};
    res1          = '{edge_time: '0, toggle: 1'b0, last: 1'b1,
                      error: metg_pkg::ERR_NONE};
    if (accept) begin
      unique case (op)
        metg_pkg::OP_START: begin
          // fresh frame, any open frame is dropped silently
          open_nxt      = 1'b1;
          bits_nxt      = '0;
          level_nxt     = 1'b1;
          prev_edge_nxt = half_t;
          cur_time_nxt  = two_half;
          pending_nxt   = two_half;
          res0.edge_time = half_t;
          res0.toggle    = 1'b1;
          n_res          = 2'd1;
        end
        metg_pkg::OP_NONE: ;
        default: begin
          if (!open_r) begin
            res0.error = metg_pkg::ERR_NO_FRAME;
            n_res      = 2'd1;
          end else if (op == metg_pkg::OP_BIT) begin
            if (bits_r >= metg_pkg::BITS_W'(metg_pkg::MAX_BITS)) begin
              // frame overflow aborts the frame
              open_nxt   = 1'b0;
              res0.error = metg_pkg::ERR_TOO_MANY;
              n_res      = 2'd1;
            end else begin
              bits_nxt = bits_r + 1'b1;
              if (in_ch.bit_value == level_r) begin
                // same level: pending edge becomes final, two more half bits
                res0.edge_time = pending_r;
                res0.toggle    = 1'b1;
                res0.last      = 1'b0;
                res1.edge_time = cur_plus_half;
                res1.toggle    = 1'b1;
                prev_edge_nxt  = cur_plus_half;
                cur_time_nxt   = cur_plus_two_half;
                pending_nxt    = cur_plus_two_half;
                n_res          = 2'd2;
              end else begin
                // level change: pending edge dropped, edge one full bit on
                res0.edge_time = prev_plus_full;
                res0.toggle    = 1'b1;
                prev_edge_nxt  = prev_plus_full;
                cur_time_nxt   = diff_cur;
                pending_nxt    = diff_cur;
                level_nxt      = in_ch.bit_value;
                n_res          = 2'd1;
              end
            end
          end else begin
            // end of frame
            open_nxt = 1'b0;
            if (level_r) begin
              cur_time_nxt   = prev_plus_stop;
              res0.edge_time = prev_plus_stop;
              n_res          = 2'd1;
            end else begin
              res0.edge_time = pending_r;
              res0.toggle    = 1'b1;
              res0.last      = 1'b0;
              res1.edge_time = cur_plus_stop;
              cur_time_nxt   = cur_plus_stop;
              level_nxt      = 1'b1;
              n_res          = 2'd2;
            end
          end
        end
      endcase
    end
  end

  assign count_nxt = count_r + n_res - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_time_r  <= '0;
      prev_edge_r <= '0;
      pending_r   <= '0;
      level_r     <= 1'b1;
      open_r      <= 1'b0;
      bits_r      <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
    end else begin
      cur_time_r  <= cur_time_nxt;
      prev_edge_r <= prev_edge_nxt;
      pending_r   <= pending_nxt;
      level_r     <= level_nxt;
      open_r      <= open_nxt;
      bits_r      <= bits_nxt;
      wr_ptr_r    <= wr_ptr_r + n_res;
      rd_ptr_r    <= rd_ptr_r + {1'b0, pop};
      count_r     <= count_nxt;
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      queue_r[wr_ptr_r] <= res0;
    end
    if (n_res == 2'd2) begin
      queue_r[wr_ptr_r + 2'd1] <= res1;
    end
  end

  assign out_ch.valid     = (count_r != 2'd0);
  assign out_ch.edge_time = queue_r[rd_ptr_r].edge_time;
  assign out_ch.toggle    = queue_r[rd_ptr_r].toggle;
  assign out_ch.last      = queue_r[rd_ptr_r].last;
  assign out_ch.error     = queue_r[rd_ptr_r].error;

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none
module tb_top;
  import metg_pkg::*;

  // run limits
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned ITEMS_PER_SET = 75;
  localparam int unsigned LONG_HOLD     = 400;

  // ------------------------------------------------------------------------
  // edge schedule: keeps its own copy of the frame timing state and the
  // register values, works out the edges every accepted request should
  // produce and checks the results as they come back
  // ------------------------------------------------------------------------
  class edge_schedule;
    logic [HALF_W-1:0] half_bit;
    logic [FULL_W-1:0] full_bit;
    logic [STOP_W-1:0] stop_len;
    logic [TIME_W-1:0] cur_time;
    logic [TIME_W-1:0] prev_edge;
    logic [TIME_W-1:0] pending_edge;
    logic              line_level;
    logic              frame_open;
    logic [BITS_W-1:0] bits_seen;
    result_t           edges_due[$];
    int unsigned       mismatches;

    function new();
      half_bit     = HALF_BIT_RESET;
      full_bit     = FULL_BIT_RESET;
      stop_len     = STOP_RESET;
      cur_time     = '0;
      prev_edge    = '0;
      pending_edge = '0;
      line_level   = 1'b1;
      frame_open   = 1'b0;
      bits_seen    = '0;
      mismatches   = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_HALF_BIT: half_bit = val[HALF_W-1:0];
        CFG_FULL_BIT: full_bit = val[FULL_W-1:0];
        CFG_STOP:     stop_len = val[STOP_W-1:0];
        default: ;
      endcase
    endfunction

    function void push(logic [TIME_W-1:0] t, logic tog, logic lst, err_t err);
      result_t r;
      r.edge_time = t;
      r.toggle    = tog;
      r.last      = lst;
      r.error     = err;
      edges_due.push_back(r);
    endfunction

    function void note_request(op_t op, logic b);
      if (op == OP_START) begin
        // a start always reopens, whatever was open before
        frame_open   = 1'b1;
        bits_seen    = '0;
        line_level   = 1'b1;
        prev_edge    = TIME_W'(half_bit);
        cur_time     = prev_edge + half_bit;
        pending_edge = cur_time;
        push(prev_edge, 1'b1, 1'b1, ERR_NONE);
      end else if (op == OP_NONE) begin
        // ignored
      end else if (!frame_open) begin
        push('0, 1'b0, 1'b1, ERR_NO_FRAME);
      end else if (op == OP_BIT) begin
        if (bits_seen >= MAX_BITS) begin
          frame_open = 1'b0;
          push('0, 1'b0, 1'b1, ERR_TOO_MANY);
        end else begin
          bits_seen = bits_seen + 1'b1;
          if (b == line_level) begin
            // same level: pending edge is final, plus one half a bit on
            push(pending_edge, 1'b1, 1'b0, ERR_NONE);
            prev_edge    = cur_time + half_bit;
            cur_time     = prev_edge + half_bit;
            pending_edge = cur_time;
            push(prev_edge, 1'b1, 1'b1, ERR_NONE);
          end else begin
            // level change: pending edge dropped, one full bit after previous
            prev_edge    = prev_edge + full_bit;
            cur_time     = prev_edge + half_bit;
            pending_edge = cur_time;
            line_level   = b;
            push(prev_edge, 1'b1, 1'b1, ERR_NONE);
          end
        end
      end else begin
        frame_open = 1'b0;
        if (line_level) begin
          cur_time = prev_edge + stop_len;
          push(cur_time, 1'b0, 1'b1, ERR_NONE);
        end else begin
          push(pending_edge, 1'b1, 1'b0, ERR_NONE);
          cur_time = cur_time + stop_len;
          push(cur_time, 1'b0, 1'b1, ERR_NONE);
          line_level = 1'b1;
        end
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (edges_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: time %0d toggle %0b last %0b error %0d",
                   got.edge_time, got.toggle, got.last, got.error);
        return;
      end
      want = edges_due.pop_front();
      if (got.edge_time !== want.edge_time || got.toggle !== want.toggle ||
          got.last !== want.last || got.error !== want.error) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected time %0d toggle %0b last %0b error %0d, got time %0d toggle %0b last %0b error %0d",
                   want.edge_time, want.toggle, want.last, want.error,
                   got.edge_time, got.toggle, got.last, got.error);
      end
    endfunction

    function int unsigned due_count();
      return edges_due.size();
    endfunction
  endclass

  // ------------------------------------------------------------------------
  // clock, channels, block
  // ------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  metg_in_if  in_ch();
  metg_out_if out_ch();

  manchester_edge_time_generator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  edge_schedule sched = new();

  // idle knobs, in percent per cycle; hold_left is the long receiver hold-off
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_left     = 0;
  int unsigned items_sent    = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // result side: check every accepted result, then decide ready for the
  // next cycle (random stalls, or a long hold-off counted down here)
  // ------------------------------------------------------------------------
  initial begin : result_sink
    result_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.edge_time = out_ch.edge_time;
        got.toggle    = out_ch.toggle;
        got.last      = out_ch.last;
        got.error     = out_ch.error;
        sched.check_result(got);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // cycle budget for the whole run
  initial begin : cycle_guard
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // ------------------------------------------------------------------------
  // request side
  // ------------------------------------------------------------------------

  // offer one request, with a random idle gap in front of it; valid stays
  // high after acceptance so back-to-back requests need no second write
  task automatic send_request(input op_t op, input logic b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid     <= 1'b0;
      in_ch.op        <= 2'($urandom_range(3));
      in_ch.bit_value <= 1'($urandom_range(1));
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.bit_value <= b;
    do @(posedge clk); while (!in_ch.ready);
    sched.note_request(op, b);
    if (op != OP_NONE) items_sent++;
  endtask

  // stop offering and wait for every expected result
  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sched.due_count() != 0);
  endtask

  // idle point: all results in, then an idle wait before the next step
  task automatic settle();
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sched.set_reg(idx, val);
  endtask

  // register settings: extremes, reset values, zero, random values
  task automatic pick_setting(input int unsigned n);
    case (n)
      0: begin
        write_reg(CFG_HALF_BIT, 13'd1);
        write_reg(CFG_FULL_BIT, 13'd1);
        write_reg(CFG_STOP, 13'd1);
      end
      1: begin
        // all ones, upper bits beyond each register width dropped
        write_reg(CFG_HALF_BIT, 13'h1FFF);
        write_reg(CFG_FULL_BIT, 13'h1FFF);
        write_reg(CFG_STOP, 13'h1FFF);
      end
      2: begin
        write_reg(CFG_HALF_BIT, 13'(HALF_BIT_RESET));
        write_reg(CFG_FULL_BIT, 13'(FULL_BIT_RESET));
        write_reg(CFG_STOP, STOP_RESET);
      end
      4: begin
        // zero times, and a write to the unused index that changes nothing
        write_reg(CFG_HALF_BIT, 13'd0);
        write_reg(CFG_FULL_BIT, 13'd0);
        write_reg(CFG_STOP, 13'd0);
        write_reg(CFG_UNUSED, 13'($urandom_range(8191)));
      end
      5: begin
        write_reg(CFG_HALF_BIT, 13'($urandom_range(8191)));
        write_reg(CFG_FULL_BIT, 13'($urandom_range(8191)));
        write_reg(CFG_STOP, 13'($urandom_range(8191)));
      end
      6: begin
        write_reg(CFG_HALF_BIT, 13'd1);
        write_reg(CFG_FULL_BIT, 13'd2047);
        write_reg(CFG_STOP, 13'd8191);
      end
      default: begin
        write_reg(CFG_HALF_BIT, 13'($urandom_range(1023, 1)));
        write_reg(CFG_FULL_BIT, 13'($urandom_range(2047, 1)));
        write_reg(CFG_STOP, 13'($urandom_range(8191, 1)));
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  // mostly whole frames with random bits; some lose their end request,
  // the rest is loose noise (stray starts, bits and ends, ignored op codes)
  task automatic send_frame(input int forced_len);
    int unsigned kind;
    int unsigned len;
    int unsigned pick;
    int unsigned i;
    kind = $urandom_range(99);
    if (forced_len >= 0) kind = 0;
    if (kind < 80) begin
      pick = $urandom_range(99);
      if (forced_len >= 0) len = forced_len;
      else if (pick < 70) len = $urandom_range(12);
      else if (pick < 85) len = $urandom_range(31, 13);
      else len = $urandom_range(35, 32);
      send_request(OP_START, 1'($urandom_range(1)));
      for (i = 0; i < len; i++) begin
        if ($urandom_range(49) == 0) send_request(OP_NONE, 1'($urandom_range(1)));
        send_request(OP_BIT, 1'($urandom_range(1)));
      end
      if ($urandom_range(9) != 0) send_request(OP_END, 1'($urandom_range(1)));
    end else begin
      len = $urandom_range(4, 1);
      for (i = 0; i < len; i++)
        send_request(op_t'($urandom_range(3)), 1'($urandom_range(1)));
    end
  endtask

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase;
    int unsigned setting;
    int unsigned goal;
    bit          paused;
    paused          = 1'b0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= OP_NONE;
    in_ch.bit_value <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= CFG_HALF_BIT;
    cfg_wdata       <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset register values
    send_request(OP_BIT, 1'b1);     // bit with no frame open
    send_request(OP_END, 1'b0);     // end with no frame open
    send_request(OP_NONE, 1'b1);    // unused op code, no result
    send_request(OP_START, 1'b0);
    send_request(OP_BIT, 1'b1);     // same as idle level: pending edge plus a new one
    send_request(OP_BIT, 1'b0);     // level change: pending edge dropped
    send_request(OP_BIT, 1'b0);     // same low level
    send_request(OP_NONE, 1'b0);    // ignored inside a frame
    send_request(OP_END, 1'b1);     // end at low level: edge plus marker
    send_request(OP_START, 1'b1);
    send_request(OP_BIT, 1'b0);
    send_request(OP_BIT, 1'b1);
    send_request(OP_END, 1'b0);     // end at high level: marker only
    send_request(OP_START, 1'b0);
    send_request(OP_BIT, 1'b0);
    send_request(OP_START, 1'b1);   // start abandons the open frame
    send_request(OP_END, 1'b1);     // end right after start
    send_request(OP_BIT, 1'b0);     // frame closed again
    send_request(OP_END, 1'b1);
    settle();

    // random part: idle mix per phase, two register settings per phase
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 71; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 71; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      for (setting = 0; setting < 2; setting++) begin
        pick_setting(phase * 2 + setting);
        goal = items_sent + ITEMS_PER_SET;
        if (phase == 0 && setting == 1) begin
          // long receiver hold-off while requests keep coming
          @(negedge clk);
          hold_left = LONG_HOLD;
          @(posedge clk);
        end
        // one over-long frame per phase so the bit limit trips
        if (setting == 0) send_frame(MAX_BITS + 1);
        while (items_sent < goal) begin
          if (phase == 1 && !paused && items_sent + 40 >= goal) begin
            // sender pause until the block has drained
            wait_all_results();
            paused = 1'b1;
          end
          send_frame(-1);
        end
        settle();
      end
    end

    if (sched.mismatches == 0 && sched.due_count() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
